[hdl/assert_macros.svh]
// Assertion macros for the checker file.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ffla_pkg.sv]
// Package for the first-fit lifetime aliasing unit: sizes, field widths,
// result struct and the slot clamp. No dependencies.
`timescale 1ns / 1ps

package ffla_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int MAX_SLOTS  = 1024;

    localparam int BYTES_W = 32;
    localparam int SLOT_W  = 10;
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int ENTRY_W = BYTES_W + SLOT_W;
    localparam int BIDX_W  = 4;

    localparam int IN_W  = 56;
    localparam int OUT_W = 16;

    // Result fields, block_index in the low bits.
    typedef struct packed {
        logic [CNT_W-1:0]  blocks_in_use;
        logic              table_full;
        logic              reused;
        logic              assigned;
        logic [BIDX_W-1:0] block_index;
    } res_t;

    localparam int RES_W = $bits(res_t);

    function automatic logic [SLOT_W-1:0] clamp_slot(input logic [SLOT_W-1:0] v);
        logic [SLOT_W-1:0] r;
        r = v;
        if (int'(v) >= MAX_SLOTS) begin
            r = SLOT_W'(MAX_SLOTS - 1);
        end
        return r;
    endfunction

endpackage

[hdl/first_fit_lifetime_aliasing_unit.sv]
// First-fit lifetime aliasing unit: top level with the scan sequencer.
// Uses ffla_pkg, ffla_ram (block table) and ffla_cmp (fit test).
//
// Each resource transaction is placed onto a table of up to 16 physical
// blocks. The first block (lowest index) that is free before the resource's
// first use and large enough is reused; otherwise a new block of exactly the
// requested size is appended, or table_full is reported when all 16 are taken.
// A frame_start bit empties the table first. Resources that are not both
// transient and used are passed over unassigned, with only blocks_in_use set.
// One result transaction comes out for every input transaction. The table is
// read one entry per cycle through its single registered read port into one
// compare unit.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register without holding off the next input transaction.
`timescale 1ns / 1ps

module first_fit_lifetime_aliasing_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [0] frame_start, [32:1] alloc_bytes, [42:33] first_use,
    // [52:43] last_use, [53] transient, [54] used, [55] zero
    input  logic [ffla_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [3:0] block_index, [4] assigned, [5] reused, [6] table_full,
    // [11:7] blocks_in_use, [15:12] zero
    output logic [ffla_pkg::OUT_W-1:0]   m_tdata
);
    import ffla_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_APPEND = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BYTES_W-1:0] need_reg, need_next;
    logic [SLOT_W-1:0]  first_reg, first_next;
    logic [SLOT_W-1:0]  last_reg, last_next;
    res_t               res_reg, res_next;
    res_t               out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    // input fields
    logic               in_frame_start;
    logic [BYTES_W-1:0] in_bytes;
    logic [SLOT_W-1:0]  in_first;
    logic [SLOT_W-1:0]  in_last;
    logic               in_transient;
    logic               in_used;
    logic [CNT_W-1:0]   in_count;

    // table port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               fit;

    logic               s_fire;
    logic               out_load;

    assign in_frame_start = s_tdata[0];
    assign in_bytes       = s_tdata[32:1];
    assign in_first       = clamp_slot(s_tdata[42:33]);
    assign in_last        = clamp_slot(s_tdata[52:43]);
    assign in_transient   = s_tdata[53];
    assign in_used        = s_tdata[54];
    assign in_count       = in_frame_start ? '0 : count_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // Read ahead: entry 0 on accept, then the entry after the one under test.
    assign ram_raddr = (state_reg == ST_IDLE) ? '0 : chk_idx_reg + IDX_W'(1);

    ffla_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffla_cmp u_cmp (
        .entry     (ram_rdata),
        .first_use (first_reg),
        .need      (need_reg),
        .fit       (fit)
    );

    always_comb begin
        state_next   = state_reg;
        chk_idx_next = chk_idx_reg;
        count_next   = count_reg;
        need_next    = need_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        ram_we       = 1'b0;
        ram_waddr    = chk_idx_reg;
        ram_wdata    = {need_reg, last_reg};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    need_next    = in_bytes;
                    first_next   = in_first;
                    last_next    = in_last;
                    count_next   = in_count;
                    chk_idx_next = '0;
                    if (in_transient && in_used) begin
                        state_next = (in_count == '0) ? ST_APPEND : ST_SCAN;
                    end else begin
                        res_next               = '0;
                        res_next.blocks_in_use = in_count;
                        state_next             = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (fit) begin
                    // reuse: keep the block size, move its free slot
                    ram_we                 = 1'b1;
                    ram_waddr              = chk_idx_reg;
                    ram_wdata              = {ram_rdata[ENTRY_W-1:SLOT_W], last_reg};
                    res_next               = '0;
                    res_next.block_index   = BIDX_W'(chk_idx_reg);
                    res_next.assigned      = 1'b1;
                    res_next.reused        = 1'b1;
                    res_next.blocks_in_use = count_reg;
                    state_next             = ST_DONE;
                end else if (CNT_W'(chk_idx_reg) + CNT_W'(1) == count_reg) begin
                    state_next = ST_APPEND;
                end else begin
                    chk_idx_next = chk_idx_reg + IDX_W'(1);
                end
            end
            ST_APPEND: begin
                res_next = '0;
                if (count_reg == CNT_W'(MAX_BLOCKS)) begin
                    res_next.table_full    = 1'b1;
                    res_next.blocks_in_use = count_reg;
                end else begin
                    ram_we                 = 1'b1;
                    ram_waddr              = count_reg[IDX_W-1:0];
                    ram_wdata              = {need_reg, last_reg};
                    count_next             = count_reg + CNT_W'(1);
                    res_next.block_index   = BIDX_W'(count_reg[IDX_W-1:0]);
                    res_next.assigned      = 1'b1;
                    res_next.blocks_in_use = count_reg + CNT_W'(1);
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg <= chk_idx_next;
        need_reg    <= need_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_W - RES_W)'(0), out_reg};

endmodule

[hdl/ffla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ffla_cmp.sv]
// Fit test: a table entry fits when it is free before the first use
// and holds at least the needed bytes. Uses ffla_pkg.
`timescale 1ns / 1ps

module ffla_cmp (
    input  logic [ffla_pkg::ENTRY_W-1:0] entry,
    input  logic [ffla_pkg::SLOT_W-1:0]  first_use,
    input  logic [ffla_pkg::BYTES_W-1:0] need,
    output logic                         fit
);
    import ffla_pkg::*;

    logic [BYTES_W-1:0] ent_bytes;
    logic [SLOT_W-1:0]  ent_free;

    assign ent_bytes = entry[ENTRY_W-1:SLOT_W];
    assign ent_free  = entry[SLOT_W-1:0];
    assign fit       = (ent_free < first_use) && (ent_bytes >= need);

endmodule

[hdl/ffla_checker.sv]
// Port-level checker for first_fit_lifetime_aliasing_unit, bound to the top.
// Uses ffla_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffla_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [ffla_pkg::IN_W-1:0]  s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [ffla_pkg::OUT_W-1:0] m_tdata
);
    import ffla_pkg::*;

    res_t res;
    logic in_unused;

    assign res       = m_tdata[RES_W-1:0];
    assign in_unused = ^s_tdata;

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready && !in_unused && 1'b0 || s_tvalid && s_tready, !s_tready, "input accepted while a transaction is in flight")
    `ASSERT_SAME(a_reuse_is_assigned, aclk, aresetn, m_tvalid && res.reused, res.assigned && !res.table_full, "reused result without assignment")
    `ASSERT_SAME(a_unassigned_index_zero, aclk, aresetn, m_tvalid && !res.assigned, res.block_index == '0, "unassigned result carries a block index")
    `ASSERT_SAME(a_index_in_table, aclk, aresetn, m_tvalid && res.assigned, {1'b0, res.block_index} < res.blocks_in_use, "block index beyond table size")
    `ASSERT_SAME(a_count_bound, aclk, aresetn, m_tvalid, res.blocks_in_use <= CNT_W'(MAX_BLOCKS) && !(res.table_full && res.blocks_in_use != CNT_W'(MAX_BLOCKS)), "block count out of range")

endmodule

bind first_fit_lifetime_aliasing_unit ffla_checker u_ffla_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
